FILE: rtl/sfl_pkg.sv
// Shared types, constants and the LFO sine table for the stereo flanger.
package sfl_pkg;

    // Default sizes handed to the top-level parameters
    localparam int DELAY_DEPTH_DEF = 65536;
    localparam int SAMPLE_BITS_DEF = 16;

    // LFO phase accumulator and sine table
    localparam int PHASE_W      = 24;
    localparam int SINE_ENTRIES = 256;
    localparam int SINE_IDX_W   = $clog2(SINE_ENTRIES);
    localparam int SINE_W       = 16;

    // Tap arithmetic: factor is Q2.30, tap is (factor * base + half) >> 30
    localparam int FACTOR_W    = 32;
    localparam int FRAC_SHIFT  = 30;
    localparam int BASE_W      = 16;
    localparam int DEPTH_RNG_W = 16;
    localparam int SCALED_W    = FACTOR_W + BASE_W;
    localparam int TAP_RAW_W   = SCALED_W + 1 - FRAC_SHIFT;

    // Gains are Q2.14; output is taken from the accumulator at bit 28
    localparam int GAIN_W     = 16;
    localparam int GAIN_SHIFT = 14;
    localparam int ACC_SHIFT  = 28;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_STEP   = 3'd0,
        CFG_BASE_DELAY   = 3'd1,
        CFG_DEPTH_RANGE  = 3'd2,
        CFG_DELAYED_GAIN = 3'd3,
        CFG_WET_GAIN     = 3'd4,
        CFG_DRY_GAIN     = 3'd5
    } cfg_index_t;

    localparam logic signed [GAIN_W-1:0] DELAYED_GAIN_RST = 16'sd16384;

    // Sequencer states, one per stage of the item
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FACTOR,
        ST_SCALE,
        ST_TAP,
        ST_READ,
        ST_SUM,
        ST_ACC,
        ST_OUT
    } state_t;

    // Stage strobes from the sequencer to the tap unit and the lanes
    typedef struct packed {
        logic accept;
        logic factor_en;
        logic scale_en;
        logic tap_en;
        logic read_en;
        logic sum_en;
        logic acc_en;
    } sfl_ctrl_t;

    typedef logic signed [SINE_W-1:0] sine_word_t;
    typedef sine_word_t sine_table_t [SINE_ENTRIES];

    // Odd 9th-order polynomial for sin(pi/2 * u), Q30
    localparam longint SIN_COEF [5] = '{
        64'sd1686629714, -64'sd693598668, 64'sd85569306, -64'sd5026995, 64'sd172272
    };

    // Quarter-wave sine, u in Q16 on [0, 65536], result Q1.15, non-negative
    function automatic sine_word_t quarter_sine(input longint u);
        longint v;
        longint r;
        int     k;
        v = (u * u) / 65536;
        r = SIN_COEF[4];
        for (k = 3; k >= 0; k--) begin
            r = SIN_COEF[k] + (r * v) / 65536;
        end
        r = (r * u) / 65536;
        r = (r + 64'sd16384) / 32768;
        if (r > 64'sd32767) begin
            r = 64'sd32767;
        end
        if (r < 64'sd0) begin
            r = 64'sd0;
        end
        return sine_word_t'(r);
    endfunction

    // Full sine table built from the quarter wave with a quadrant fold
    function automatic sine_table_t build_sine_table();
        sine_table_t tab;
        longint      t;
        longint      u;
        longint      quad;
        sine_word_t  s;
        int          i;
        for (i = 0; i < SINE_ENTRIES; i++) begin
            t    = longint'(i) * 4;
            quad = (t / SINE_ENTRIES) & 64'sd3;
            u    = ((t % SINE_ENTRIES) * 65536) / SINE_ENTRIES;
            if ((quad & 64'sd1) != 64'sd0) begin
                u = 64'sd65536 - u;
            end
            s = quarter_sine(u);
            tab[i] = ((quad & 64'sd2) != 64'sd0) ? -s : s;
        end
        return tab;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

FILE: rtl/sfl_tap_gen.sv
// Shared tap unit: LFO phase, sine lookup, tap length and delay memory addresses.
module sfl_tap_gen #(
    parameter int DELAY_DEPTH = sfl_pkg::DELAY_DEPTH_DEF,
    parameter int ADDR_W      = $clog2(DELAY_DEPTH)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sfl_pkg::sfl_ctrl_t                  ctrl,
    input  logic [sfl_pkg::PHASE_W-1:0]         phase_step,
    input  logic [sfl_pkg::BASE_W-1:0]          base_delay,
    input  logic [sfl_pkg::DEPTH_RNG_W-1:0]     depth_range,
    output logic [ADDR_W-1:0]                   wr_addr,
    output logic [ADDR_W-1:0]                   rd_addr,
    output logic                                rd_hit
);

    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(DELAY_DEPTH - 1);
    localparam logic [ADDR_W:0]   DEPTH_CNT  = (ADDR_W + 1)'(DELAY_DEPTH);
    localparam logic signed [sfl_pkg::SINE_W+sfl_pkg::DEPTH_RNG_W+1:0] FACTOR_ONE =
        (sfl_pkg::SINE_W + sfl_pkg::DEPTH_RNG_W + 2)'(64'sd1 <<< sfl_pkg::FRAC_SHIFT);
    localparam logic [sfl_pkg::SCALED_W:0] TAP_HALF =
        (sfl_pkg::SCALED_W + 1)'(64'd1 << (sfl_pkg::FRAC_SHIFT - 1));

    logic [ADDR_W-1:0]                  wp_reg;
    logic [ADDR_W-1:0]                  wp_next;
    logic [ADDR_W:0]                    fill_reg;
    logic [sfl_pkg::PHASE_W-1:0]        phase_reg;
    logic [sfl_pkg::PHASE_W-1:0]        phase_next;
    sfl_pkg::sine_word_t                sine_reg;
    logic [sfl_pkg::FACTOR_W-1:0]       factor_reg;
    logic [sfl_pkg::FACTOR_W-1:0]       factor_next;
    logic [sfl_pkg::SCALED_W-1:0]       scaled_reg;
    logic [ADDR_W-1:0]                  tap_reg;
    logic [ADDR_W-1:0]                  tap_next;

    logic signed [sfl_pkg::SINE_W+sfl_pkg::DEPTH_RNG_W:0]   swing;
    logic signed [sfl_pkg::SINE_W+sfl_pkg::DEPTH_RNG_W+1:0] factor_sum;
    logic [sfl_pkg::SCALED_W:0]                             scaled_rnd;
    logic [sfl_pkg::TAP_RAW_W-1:0]                          tap_raw;
    logic [ADDR_W:0]                                        rd_diff;

    // Pointer and phase advance
    assign wp_next    = (wp_reg == LAST_ADDR) ? '0 : wp_reg + 1'b1;
    assign phase_next = phase_reg + phase_step;
    assign wr_addr    = wp_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg    <= '0;
            fill_reg  <= '0;
            phase_reg <= '0;
        end else if (ctrl.accept) begin
            wp_reg    <= wp_next;
            phase_reg <= phase_next;
            if (fill_reg != DEPTH_CNT) begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    // Sine lookup on the phase from before the advance
    always_ff @(posedge aclk) begin
        if (ctrl.accept) begin
            sine_reg <= sfl_pkg::SINE_TABLE[
                phase_reg[sfl_pkg::PHASE_W-1 -: sfl_pkg::SINE_IDX_W]];
        end
    end

    // factor = 1.0 + sine * depth, floored at zero
    assign swing       = sine_reg * $signed({1'b0, depth_range});
    assign factor_sum  = FACTOR_ONE + (sfl_pkg::SINE_W + sfl_pkg::DEPTH_RNG_W + 2)'(swing);
    assign factor_next = factor_sum[sfl_pkg::SINE_W+sfl_pkg::DEPTH_RNG_W+1] ?
                         '0 : factor_sum[sfl_pkg::FACTOR_W-1:0];

    always_ff @(posedge aclk) begin
        if (ctrl.factor_en) begin
            factor_reg <= factor_next;
        end
    end

    // Scale by the base delay
    always_ff @(posedge aclk) begin
        if (ctrl.scale_en) begin
            scaled_reg <= factor_reg * base_delay;
        end
    end

    // Round to whole samples and clamp to the memory depth
    assign scaled_rnd = {1'b0, scaled_reg} + TAP_HALF;
    assign tap_raw    = scaled_rnd[sfl_pkg::SCALED_W:sfl_pkg::FRAC_SHIFT];
    assign tap_next   = (32'(tap_raw) > 32'(DELAY_DEPTH - 1)) ? LAST_ADDR : ADDR_W'(tap_raw);

    always_ff @(posedge aclk) begin
        if (ctrl.tap_en) begin
            tap_reg <= tap_next;
        end
    end

    // Read address behind the write pointer, wrapped; entries past the fill read as zero
    assign rd_diff = {1'b0, wp_reg} - {1'b0, tap_reg};
    assign rd_addr = rd_diff[ADDR_W] ? ADDR_W'(rd_diff + DEPTH_CNT) : rd_diff[ADDR_W-1:0];
    assign rd_hit  = ({1'b0, tap_reg} < fill_reg);

endmodule

FILE: rtl/sfl_lane.sv
// One channel lane: delay memory, delayed-sample mix and output saturation.
module sfl_lane #(
    parameter int DELAY_DEPTH = sfl_pkg::DELAY_DEPTH_DEF,
    parameter int SAMPLE_BITS = sfl_pkg::SAMPLE_BITS_DEF,
    parameter int ADDR_W      = $clog2(DELAY_DEPTH)
) (
    input  logic                                aclk,
    input  sfl_pkg::sfl_ctrl_t                  ctrl,
    input  logic signed [SAMPLE_BITS-1:0]       x_in,
    input  logic [ADDR_W-1:0]                   wr_addr,
    input  logic [ADDR_W-1:0]                   rd_addr,
    input  logic                                rd_hit,
    input  logic signed [sfl_pkg::GAIN_W-1:0]   delayed_gain,
    input  logic signed [sfl_pkg::GAIN_W-1:0]   wet_gain,
    input  logic signed [sfl_pkg::GAIN_W-1:0]   dry_gain,
    output logic signed [SAMPLE_BITS-1:0]       y_out
);

    localparam int SUM_W  = SAMPLE_BITS + sfl_pkg::GAIN_W + 1;
    localparam int WET_W  = SUM_W + sfl_pkg::GAIN_W;
    localparam int DRY_W  = SAMPLE_BITS + sfl_pkg::GAIN_W;
    localparam int ACC_W  = WET_W + 1;
    localparam int RND_W  = ACC_W - sfl_pkg::ACC_SHIFT;
    localparam logic signed [ACC_W-1:0] ROUND_BIAS =
        ACC_W'(64'sd1 <<< (sfl_pkg::ACC_SHIFT - 1));

    logic signed [SAMPLE_BITS-1:0] delay_mem [DELAY_DEPTH];
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] dly_reg;
    logic                          hit_reg;
    logic signed [SUM_W-1:0]       sum_reg;
    logic signed [SUM_W-1:0]       sum_next;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [ACC_W-1:0]       acc_next;

    logic signed [SAMPLE_BITS-1:0] dly_sel;
    logic signed [DRY_W-1:0]       dly_prod;
    logic signed [WET_W-1:0]       wet_prod;
    logic signed [DRY_W-1:0]       dry_prod;
    logic signed [ACC_W-1:0]       acc_rnd;
    logic signed [RND_W-1:0]       rnd;
    logic                          ovf;

    // Delay memory: write on accept, registered read later in the item
    always_ff @(posedge aclk) begin
        if (ctrl.accept) begin
            delay_mem[wr_addr] <= x_in;
        end
        if (ctrl.read_en) begin
            dly_reg <= delay_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.accept) begin
            x_reg <= x_in;
        end
        if (ctrl.read_en) begin
            hit_reg <= rd_hit;
        end
    end

    // in + delayed * delayed_gain, both Q.29
    assign dly_sel  = hit_reg ? dly_reg : '0;
    assign dly_prod = dly_sel * delayed_gain;
    assign sum_next = (SUM_W'(x_reg) <<< sfl_pkg::GAIN_SHIFT) + SUM_W'(dly_prod);

    always_ff @(posedge aclk) begin
        if (ctrl.sum_en) begin
            sum_reg <= sum_next;
        end
    end

    // wet * sum + dry * in, Q.43
    assign wet_prod = wet_gain * sum_reg;
    assign dry_prod = dry_gain * x_reg;
    assign acc_next = ACC_W'(wet_prod) + (ACC_W'(dry_prod) <<< sfl_pkg::GAIN_SHIFT);

    always_ff @(posedge aclk) begin
        if (ctrl.acc_en) begin
            acc_reg <= acc_next;
        end
    end

    // Round half up and saturate to the sample range
    assign acc_rnd = acc_reg + ROUND_BIAS;
    assign rnd     = acc_rnd[ACC_W-1:sfl_pkg::ACC_SHIFT];
    assign ovf     = !((&rnd[RND_W-1:SAMPLE_BITS-1]) || !(|rnd[RND_W-1:SAMPLE_BITS-1]));
    assign y_out   = ovf ? {rnd[RND_W-1], {(SAMPLE_BITS-1){~rnd[RND_W-1]}}}
                         : rnd[SAMPLE_BITS-1:0];

endmodule

FILE: rtl/stereo_flanger_unit.sv
// Stereo flanger top level: sequencer, config registers, two lanes and output merge.
// Items pass the stage sequencer (sine, factor, scale, tap, memory read, mix sum,
//   mix accumulate, output load); a new item is accepted only in idle, after the
//   last one is loaded, and the output load stalls while a result is not taken.
// The output register lets the next item be accepted while a result waits.
// Reset (aresetn, synchronous, active low) clears pointer, phase, fill count,
//   sequencer and config (delayed gain to 1.0); memory reads as zero until written.
module stereo_flanger_unit #(
    parameter int DELAY_DEPTH = sfl_pkg::DELAY_DEPTH_DEF,
    parameter int SAMPLE_BITS = sfl_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // [SAMPLE_BITS-1:0] left_in, [2*SAMPLE_BITS-1:SAMPLE_BITS] right_in, zero pad
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [SAMPLE_BITS-1:0] left_out, [2*SAMPLE_BITS-1:SAMPLE_BITS] right_out, zero pad
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   m_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic                                 cfg_wr_en,
    input  logic [sfl_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sfl_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    localparam int ADDR_W = $clog2(DELAY_DEPTH);
    localparam int DATA_W = ((2*SAMPLE_BITS+7)/8)*8;

    sfl_pkg::state_t                     state_reg;
    sfl_pkg::state_t                     state_next;
    sfl_pkg::sfl_ctrl_t                  ctrl;
    logic                                out_load;

    logic [sfl_pkg::PHASE_W-1:0]         phase_step_reg;
    logic [sfl_pkg::BASE_W-1:0]          base_delay_reg;
    logic [sfl_pkg::DEPTH_RNG_W-1:0]     depth_range_reg;
    logic signed [sfl_pkg::GAIN_W-1:0]   delayed_gain_reg;
    logic signed [sfl_pkg::GAIN_W-1:0]   wet_gain_reg;
    logic signed [sfl_pkg::GAIN_W-1:0]   dry_gain_reg;

    logic [ADDR_W-1:0]                   wr_addr;
    logic [ADDR_W-1:0]                   rd_addr;
    logic                                rd_hit;
    logic signed [SAMPLE_BITS-1:0]       left_y;
    logic signed [SAMPLE_BITS-1:0]       right_y;

    logic [DATA_W-1:0]                   m_tdata_reg;
    logic                                m_tvalid_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg   <= '0;
            base_delay_reg   <= '0;
            depth_range_reg  <= '0;
            delayed_gain_reg <= sfl_pkg::DELAYED_GAIN_RST;
            wet_gain_reg     <= '0;
            dry_gain_reg     <= '0;
        end else if (cfg_wr_en) begin
            unique case (sfl_pkg::cfg_index_t'(cfg_index))
                sfl_pkg::CFG_PHASE_STEP:   phase_step_reg   <= cfg_wdata;
                sfl_pkg::CFG_BASE_DELAY:   base_delay_reg   <= cfg_wdata[sfl_pkg::BASE_W-1:0];
                sfl_pkg::CFG_DEPTH_RANGE:  depth_range_reg  <=
                    cfg_wdata[sfl_pkg::DEPTH_RNG_W-1:0];
                sfl_pkg::CFG_DELAYED_GAIN: delayed_gain_reg <= cfg_wdata[sfl_pkg::GAIN_W-1:0];
                sfl_pkg::CFG_WET_GAIN:     wet_gain_reg     <= cfg_wdata[sfl_pkg::GAIN_W-1:0];
                sfl_pkg::CFG_DRY_GAIN:     dry_gain_reg     <= cfg_wdata[sfl_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sfl_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign out_load = !m_tvalid_reg || m_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sfl_pkg::ST_IDLE:   if (s_tvalid) state_next = sfl_pkg::ST_FACTOR;
            sfl_pkg::ST_FACTOR: state_next = sfl_pkg::ST_SCALE;
            sfl_pkg::ST_SCALE:  state_next = sfl_pkg::ST_TAP;
            sfl_pkg::ST_TAP:    state_next = sfl_pkg::ST_READ;
            sfl_pkg::ST_READ:   state_next = sfl_pkg::ST_SUM;
            sfl_pkg::ST_SUM:    state_next = sfl_pkg::ST_ACC;
            sfl_pkg::ST_ACC:    state_next = sfl_pkg::ST_OUT;
            sfl_pkg::ST_OUT:    if (out_load) state_next = sfl_pkg::ST_IDLE;
            default:            state_next = sfl_pkg::ST_IDLE;
        endcase
    end

    // Stage strobes
    always_comb begin
        ctrl     = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            sfl_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                ctrl.accept = s_tvalid;
            end
            sfl_pkg::ST_FACTOR: ctrl.factor_en = 1'b1;
            sfl_pkg::ST_SCALE:  ctrl.scale_en  = 1'b1;
            sfl_pkg::ST_TAP:    ctrl.tap_en    = 1'b1;
            sfl_pkg::ST_READ:   ctrl.read_en   = 1'b1;
            sfl_pkg::ST_SUM:    ctrl.sum_en    = 1'b1;
            sfl_pkg::ST_ACC:    ctrl.acc_en    = 1'b1;
            default: ;
        endcase
    end

    // Shared tap unit
    sfl_tap_gen #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_tap_gen (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .phase_step  (phase_step_reg),
        .base_delay  (base_delay_reg),
        .depth_range (depth_range_reg),
        .wr_addr     (wr_addr),
        .rd_addr     (rd_addr),
        .rd_hit      (rd_hit)
    );

    // Left and right lanes
    sfl_lane #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .ADDR_W      (ADDR_W)
    ) u_lane_left (
        .aclk         (aclk),
        .ctrl         (ctrl),
        .x_in         (s_tdata[SAMPLE_BITS-1:0]),
        .wr_addr      (wr_addr),
        .rd_addr      (rd_addr),
        .rd_hit       (rd_hit),
        .delayed_gain (delayed_gain_reg),
        .wet_gain     (wet_gain_reg),
        .dry_gain     (dry_gain_reg),
        .y_out        (left_y)
    );

    sfl_lane #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .ADDR_W      (ADDR_W)
    ) u_lane_right (
        .aclk         (aclk),
        .ctrl         (ctrl),
        .x_in         (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .wr_addr      (wr_addr),
        .rd_addr      (rd_addr),
        .rd_hit       (rd_hit),
        .delayed_gain (delayed_gain_reg),
        .wet_gain     (wet_gain_reg),
        .dry_gain     (dry_gain_reg),
        .y_out        (right_y)
    );

    // Merge the lane results into the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == sfl_pkg::ST_OUT && out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == sfl_pkg::ST_OUT && out_load) begin
            m_tdata_reg <= DATA_W'({right_y, left_y});
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

    // An accepted item always starts the factor stage next
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == sfl_pkg::ST_FACTOR))
        else $error("accepted item did not enter the factor stage");

    // A pending result that is not taken holds the sequencer in the output stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sfl_pkg::ST_OUT && m_tvalid && !m_tready)
        |=> (state_reg == sfl_pkg::ST_OUT && m_tvalid))
        else $error("result overwritten while still pending");

    // At most one stage strobe per cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({ctrl.accept, ctrl.factor_en, ctrl.scale_en, ctrl.tap_en,
                  ctrl.read_en, ctrl.sum_en, ctrl.acc_en}))
        else $error("more than one stage strobe active");

    // A new result appears only after the output stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> ($past(state_reg) == sfl_pkg::ST_OUT))
        else $error("result raised outside the output stage");

endmodule
